/* rtl/lr_pkg.sv */
`timescale 1ns / 1ps
// Shared definitions for the line rasterizer core.
// No dependencies; imported by the front classifier and the back stepper.
package lr_pkg;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

endpackage

/* rtl/lr_front.sv */
`timescale 1ns / 1ps
// Front classifier: decodes an input transaction and works out directions,
// absolute deltas, the steep flag and the single-pixel case. Uses lr_pkg.
module lr_front #(
  parameter int COORD_BITS = 10
) (
  input  lr_pkg::op_t                  op,
  input  logic [COORD_BITS-1:0]        start_x,
  input  logic [COORD_BITS-1:0]        start_y,
  input  logic [COORD_BITS-1:0]        end_x,
  input  logic [COORD_BITS-1:0]        end_y,
  output logic [6*COORD_BITS+4:0]      entry
);
  import lr_pkg::*;

  logic                  x_neg;
  logic                  y_neg;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  is_steep;
  logic [COORD_BITS-1:0] major;
  logic [COORD_BITS-1:0] minor;
  logic                  single;

  always_comb begin
    x_neg    = end_x < start_x;
    y_neg    = end_y < start_y;
    adx      = x_neg ? (start_x - end_x) : (end_x - start_x);
    ady      = y_neg ? (start_y - end_y) : (end_y - start_y);
    is_steep = ady > adx;
    major    = is_steep ? ady : adx;
    minor    = is_steep ? adx : ady;
    single   = (start_x == end_x) && (start_y == end_y);
  end

  // pack from the lowest bit up: op, sx, sy, ex, ey, major, minor, xneg, yneg, steep, single
  assign entry = {single, is_steep, y_neg, x_neg, minor, major,
                  end_y, end_x, start_y, start_x, op};

endmodule

/* rtl/lr_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue between the front classifier and the back stepper.
// No package dependencies.
module lr_queue #(
  parameter int WIDTH = 65
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/lr_back.sv */
`timescale 1ns / 1ps
// Back stepper: holds the line state, runs one Bresenham step per popped
// advance transaction while a line is running and drives the output register. Uses lr_pkg.
module lr_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     entry_valid,
  output logic                     entry_ready,
  input  logic [6*COORD_BITS+4:0]  entry,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     pixel_valid,
  output logic [COORD_BITS-1:0]    pixel_x,
  output logic [COORD_BITS-1:0]    pixel_y,
  output logic                     last_pixel
);
  import lr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 3;

  op_t           e_op;
  logic [CB-1:0] e_sx, e_sy, e_ex, e_ey, e_major, e_minor;
  logic          e_xneg, e_yneg, e_steep, e_single;

  logic [CB-1:0] cur_x, cur_y, stop_x, stop_y;
  logic [CB-1:0] delta_major, delta_minor;
  logic [DW-1:0] decision;
  logic          x_dir_neg, y_dir_neg, steep, busy;

  logic          pop;
  logic          minor_step;
  logic          x_move, y_move;
  logic [CB-1:0] step_x, step_y;
  logic [DW-1:0] two_minor, two_major, dec_inc, dec_step, dec_start;
  logic          step_done;

  assign {e_single, e_steep, e_yneg, e_xneg, e_minor, e_major,
          e_ey, e_ex, e_sy, e_sx} = entry[6*CB+4:1];
  assign e_op = op_t'(entry[0]);

  assign entry_ready = !out_valid || out_ready;
  assign pop         = entry_valid && entry_ready;

  always_comb begin
    minor_step = !decision[DW-1];
    x_move     = steep ? minor_step : 1'b1;
    y_move     = steep ? 1'b1 : minor_step;
    step_x     = !x_move ? cur_x : (x_dir_neg ? cur_x - CB'(1) : cur_x + CB'(1));
    step_y     = !y_move ? cur_y : (y_dir_neg ? cur_y - CB'(1) : cur_y + CB'(1));
    two_minor  = {2'b00, delta_minor, 1'b0};
    two_major  = {2'b00, delta_major, 1'b0};
    dec_inc    = minor_step ? (two_minor - two_major) : two_minor;
    dec_step   = decision + dec_inc;
    dec_start  = {2'b00, e_minor, 1'b0} - {3'b000, e_major};
    step_done  = steep ? (step_y == stop_y) : (step_x == stop_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      busy        <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      stop_x      <= '0;
      stop_y      <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      decision    <= '0;
      x_dir_neg   <= 1'b0;
      y_dir_neg   <= 1'b0;
      steep       <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        unique case (e_op)
          OP_START: begin
            cur_x       <= e_sx;
            cur_y       <= e_sy;
            stop_x      <= e_ex;
            stop_y      <= e_ey;
            delta_major <= e_major;
            delta_minor <= e_minor;
            decision    <= dec_start;
            x_dir_neg   <= e_xneg;
            y_dir_neg   <= e_yneg;
            steep       <= e_steep;
            busy        <= !e_single;
          end
          OP_ADVANCE: begin
            if (busy) begin
              cur_x    <= step_x;
              cur_y    <= step_y;
              decision <= dec_step;
              busy     <= !step_done;
            end
          end
          default: begin
            busy <= busy;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (e_op)
        OP_START: begin
          pixel_valid <= 1'b1;
          pixel_x     <= e_sx;
          pixel_y     <= e_sy;
          last_pixel  <= e_single;
        end
        OP_ADVANCE: begin
          pixel_valid <= busy;
          pixel_x     <= busy ? step_x : '0;
          pixel_y     <= busy ? step_y : '0;
          last_pixel  <= busy && step_done;
        end
        default: begin
          pixel_valid <= 1'b0;
          pixel_x     <= '0;
          pixel_y     <= '0;
          last_pixel  <= 1'b0;
        end
      endcase
    end
  end

  a_start_sets_busy: assert property (@(posedge clk) disable iff (rst)
    pop && e_op == OP_START && !e_single |=> busy)
    else $error("busy not set after a multi-pixel start");

  a_idle_advance_invalid: assert property (@(posedge clk) disable iff (rst)
    pop && e_op == OP_ADVANCE && !busy |=> out_valid && !pixel_valid && !last_pixel)
    else $error("advance while idle did not give an invalid result");

  a_busy_fall_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> out_valid && last_pixel && pixel_valid)
    else $error("line ended without a last pixel");

  a_last_is_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_pixel |-> pixel_valid)
    else $error("last pixel flagged on an invalid result");

endmodule

/* rtl/line_rasterizer_core.sv */
`timescale 1ns / 1ps
// Top level of the Bresenham line rasterizer: front classifier, two-entry
// queue and back stepper. Depends on lr_pkg, lr_front, lr_queue and lr_back.
//
// A start transaction (tuser op = 0) loads both endpoints and returns the first
// endpoint; each advance transaction (op = 1) returns the next pixel of the line
// in any of the eight octants, with tlast on the end point. An advance with no
// line running returns one result with tuser pixel_valid = 0 and zero fields.
// A start during a running line drops that line. Every input transaction gives
// exactly one output transaction. Throughput is one transaction per clock while
// the output is not stalled, set by the back stepper, which updates the decision
// term and current point together; each input transaction is written into the
// queue, then popped by the back stepper, and its result is held in the output
// register until it is taken on the master side.
module line_rasterizer_core #(
  parameter int COORD_BITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // start_x, start_y, end_x, end_y (lowest bits first), zero padded to bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]      s_tdata,
  // op
  input  logic                                   s_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // pixel_x, pixel_y (lowest bits first), zero padded to bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
  // pixel_valid
  output logic                                   m_tuser,
  // last_pixel
  output logic                                   m_tlast
);
  import lr_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int ENTRY_W = 6*COORD_BITS + 5;
  localparam int OUT_W   = ((2*COORD_BITS+7)/8)*8;

  logic [ENTRY_W-1:0] front_entry;
  logic [ENTRY_W-1:0] q_entry;
  logic               q_valid;
  logic               q_ready;
  logic [CB-1:0]      pix_x;
  logic [CB-1:0]      pix_y;

  lr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .op      (op_t'(s_tuser)),
    .start_x (s_tdata[CB-1:0]),
    .start_y (s_tdata[2*CB-1:CB]),
    .end_x   (s_tdata[3*CB-1:2*CB]),
    .end_y   (s_tdata[4*CB-1:3*CB]),
    .entry   (front_entry)
  );

  lr_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_data  (front_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_entry)
  );

  lr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (q_valid),
    .entry_ready (q_ready),
    .entry       (q_entry),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .pixel_valid (m_tuser),
    .pixel_x     (pix_x),
    .pixel_y     (pix_y),
    .last_pixel  (m_tlast)
  );

  assign m_tdata = OUT_W'({pix_y, pix_x});

endmodule

/* verif/line_rasterizer_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for line_rasterizer_core: predicts each pixel of the
// Bresenham walk and compares it field by field. Depends on lr_pkg and the RTL.
module line_rasterizer_core_tb;
  import lr_pkg::*;

  localparam int COORD_BITS  = 10;
  localparam int IN_BITS     = ((4*COORD_BITS+7)/8)*8;
  localparam int OUT_BITS    = ((2*COORD_BITS+7)/8)*8;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic [COORD_BITS-1:0] coord_t;

  class pixel_scoreboard;
    typedef struct packed {
      logic   valid;
      coord_t x;
      coord_t y;
      logic   last;
    } pixel_t;

    pixel_t              expected_pixels[$];
    int                  errors;
    coord_t              cur_x, cur_y, stop_x, stop_y;
    coord_t              delta_major, delta_minor;
    logic signed [COORD_BITS+2:0] decision;
    logic                x_dir_neg, y_dir_neg, steep, busy;

    function new();
      errors      = 0;
      cur_x       = '0;
      cur_y       = '0;
      stop_x      = '0;
      stop_y      = '0;
      delta_major = '0;
      delta_minor = '0;
      decision    = '0;
      x_dir_neg   = 1'b0;
      y_dir_neg   = 1'b0;
      steep       = 1'b0;
      busy        = 1'b0;
    endfunction

    function void note_request(op_t op, logic [IN_BITS-1:0] data);
      coord_t sx, sy, ex, ey, adx, ady;
      logic   minor_step, done;
      pixel_t px;
      sx = data[0 +: COORD_BITS];
      sy = data[COORD_BITS +: COORD_BITS];
      ex = data[2*COORD_BITS +: COORD_BITS];
      ey = data[3*COORD_BITS +: COORD_BITS];
      if (op == OP_START) begin
        x_dir_neg   = ex < sx;
        y_dir_neg   = ey < sy;
        adx         = x_dir_neg ? sx - ex : ex - sx;
        ady         = y_dir_neg ? sy - ey : ey - sy;
        steep       = ady > adx;
        delta_major = steep ? ady : adx;
        delta_minor = steep ? adx : ady;
        decision    = signed'({2'b0, delta_minor, 1'b0}) - signed'({3'b0, delta_major});
        cur_x       = sx;
        cur_y       = sy;
        stop_x      = ex;
        stop_y      = ey;
        done        = (sx == ex) && (sy == ey);
        busy        = !done;
        px          = '{1'b1, cur_x, cur_y, done};
      end else if (!busy) begin
        px = '{1'b0, '0, '0, 1'b0};
      end else begin
        minor_step = !decision[COORD_BITS+2];
        if (steep) begin
          cur_y = y_dir_neg ? cur_y - 1'b1 : cur_y + 1'b1;
          if (minor_step) cur_x = x_dir_neg ? cur_x - 1'b1 : cur_x + 1'b1;
        end else begin
          cur_x = x_dir_neg ? cur_x - 1'b1 : cur_x + 1'b1;
          if (minor_step) cur_y = y_dir_neg ? cur_y - 1'b1 : cur_y + 1'b1;
        end
        decision = decision + signed'({2'b0, delta_minor, 1'b0});
        if (minor_step) decision = decision - signed'({2'b0, delta_major, 1'b0});
        done = steep ? (cur_y == stop_y) : (cur_x == stop_x);
        if (done) busy = 1'b0;
        px = '{1'b1, cur_x, cur_y, done};
      end
      expected_pixels.push_back(px);
    endfunction

    function void check_pixel(logic valid, coord_t x, coord_t y, logic last);
      pixel_t px;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel transaction: valid=%0b x=%0d y=%0d last=%0b",
               valid, x, y, last);
        errors++;
        return;
      end
      px = expected_pixels.pop_front();
      if (valid !== px.valid) begin
        $error("pixel_valid: expected %0b, got %0b", px.valid, valid);
        errors++;
      end
      if (x !== px.x) begin
        $error("pixel_x: expected %0d, got %0d", px.x, x);
        errors++;
      end
      if (y !== px.y) begin
        $error("pixel_y: expected %0d, got %0d", px.y, y);
        errors++;
      end
      if (last !== px.last) begin
        $error("last_pixel: expected %0b, got %0b", px.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata  = '0;
  logic                s_tuser  = OP_START;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  pixel_scoreboard sb;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_left     = 0;
  bit pressure_req  = 1'b0;
  int cycle_count   = 0;

  line_rasterizer_core #(.COORD_BITS(COORD_BITS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_pixel(m_tuser, m_tdata[0 +: COORD_BITS],
                     m_tdata[COORD_BITS +: COORD_BITS], m_tlast);
  end

  // hold off the output for a long stretch on request, else stall at random
  always @(negedge clk) begin
    if (pressure_req) begin
      hold_left    = 250;
      pressure_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_item(op_t op, logic [IN_BITS-1:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, data);
  endtask

  task automatic run_line(int sx, int sy, int ex, int ey, int n_adv);
    send_item(OP_START, IN_BITS'({coord_t'(ey), coord_t'(ex), coord_t'(sy), coord_t'(sx)}));
    repeat (n_adv) send_item(OP_ADVANCE, IN_BITS'({$urandom, $urandom}));
  endtask

  task automatic random_line(output int n_items);
    int sx, sy, ex, ey, dx, dy, reach, major, n_adv, pick;
    sx    = $urandom_range(COORD_MAX);
    sy    = $urandom_range(COORD_MAX);
    pick  = $urandom_range(99);
    reach = (pick < 10) ? COORD_MAX : ((pick < 30) ? 40 : 12);
    dx    = $urandom_range(reach);
    dy    = $urandom_range(reach);
    if ($urandom_range(1)) dx = -dx;
    if ($urandom_range(1)) dy = -dy;
    ex = sx + dx;
    if (ex < 0 || ex > COORD_MAX) ex = sx - dx;
    ex = (ex < 0) ? 0 : ((ex > COORD_MAX) ? COORD_MAX : ex);
    ey = sy + dy;
    if (ey < 0 || ey > COORD_MAX) ey = sy - dy;
    ey = (ey < 0) ? 0 : ((ey > COORD_MAX) ? COORD_MAX : ey);
    dx    = (ex > sx) ? ex - sx : sx - ex;
    dy    = (ey > sy) ? ey - sy : sy - ey;
    major = (dx > dy) ? dx : dy;
    pick  = $urandom_range(99);
    if (pick < 70) n_adv = major;
    else if (pick < 85) n_adv = major + $urandom_range(1, 3);
    else n_adv = $urandom_range(major);
    // truncate long lines; the next start drops them
    if (n_adv > 60) n_adv = $urandom_range(5, 60);
    run_line(sx, sy, ex, ey, n_adv);
    n_items = 1 + n_adv;
  endtask

  task automatic run_random(int target, bit with_pressure);
    int sent, n;
    bit pressed;
    sent    = 0;
    pressed = 1'b0;
    while (sent < target) begin
      random_line(n);
      sent += n;
      if (with_pressure && !pressed && sent > target / 3) begin
        pressure_req = 1'b1;
        pressed      = 1'b1;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(OP_ADVANCE, '1);
    run_line(0, 0, 0, 0, 1);
    run_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1, 2);
    run_line(0, 0, 1, 3, 3);
    run_line(COORD_MAX, 0, COORD_MAX - 3, 2, 1);
    run_line(0, COORD_MAX, COORD_MAX, 0, 2);
    run_line(10, 10, 10, 12, 2);
    run_line(512, 9, 510, 9, 2);
    run_line(7, 7, 9, 9, 2);

    tx_idle_pct = 0;  rx_stall_pct = 0;
    run_random(185, 1'b1);
    tx_idle_pct = 51; rx_stall_pct = 0;
    run_random(185, 1'b0);
    tx_idle_pct = 0;  rx_stall_pct = 51;
    run_random(185, 1'b0);
    tx_idle_pct = 25; rx_stall_pct = 25;
    run_random(185, 1'b0);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
